// File: src/lbe_pkg.sv
package lbe_pkg;

	// Fixed field widths of the channels and the register.
	localparam int DEG_W  = 5;
	localparam int XW     = 32;
	localparam int VW     = 48;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam int DEF_MAX_DEGREE = 31;
	localparam int DEF_FRAC_BITS  = 30;

	// Operand, product and result widths of the shared multiplier.
	localparam int OPW    = 64;
	localparam int HALF_W = OPW / 2;
	localparam int ACC_W  = 2 * OPW;
	localparam int MAG_W  = 61;
	localparam int MRES_W = MAG_W + 1;
	localparam int SUM_W  = MRES_W + 1;

	localparam logic [ACC_W-1:0] MUL_LIM = ACC_W'(1) << 60;

	localparam logic signed [XW-1:0] X_ONE = 32'sh4000_0000;
	localparam logic signed [XW-1:0] X_NEG = 32'shC000_0000;

	localparam logic [DEG_W-1:0] DEGREE_RESET = 5'd3;

	// floor(sqrt(k * 2^80)), one root digit per loop pass.
	function automatic logic [63:0] root_scaled(input logic [63:0] k);
		logic [63:0] hi;
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] pair;
		logic [63:0] trial;
		hi   = k << 16;
		rem  = '0;
		root = '0;
		for (int p = 63; p >= 0; p--) begin
			pair  = (p >= 32) ? ((hi >> (2 * (p - 32))) & 64'd3) : 64'd0;
			rem   = (rem << 2) | pair;
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	// Restoring long division, used only on constants while the tables are built.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r    = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// sqrt(k) * num / den in unsigned Q.32, rounded half up.
	function automatic logic [63:0] make_coef(input logic [63:0] k, input logic [63:0] num,
		input logic [63:0] den);
		logic [63:0] d;
		d = den << 8;
		return udiv64(root_scaled(k) * num + (d >> 1), d);
	endfunction

	function automatic logic [63:0] coef_a(input int n);
		logic [63:0] nn;
		nn = 64'(n);
		if (n == 0) begin
			return '0;
		end
		return make_coef((2 * nn + 1) * (2 * nn + 3), 64'd1, nn + 1);
	endfunction

	function automatic logic [63:0] coef_b(input int n);
		logic [63:0] nn;
		nn = 64'(n);
		if (n == 0) begin
			return '0;
		end
		return make_coef((2 * nn + 3) * (2 * nn - 1), nn, (2 * nn - 1) * (nn + 1));
	endfunction

	function automatic logic [63:0] coef_c(input int n);
		logic [63:0] nn;
		nn = 64'(n);
		if (n == 0) begin
			return '0;
		end
		return make_coef((2 * nn + 1) * (2 * nn + 3), 64'd1, 64'd1);
	endfunction

	function automatic logic [63:0] coef_d(input int n);
		logic [63:0] nn;
		nn = 64'(n);
		if (n == 0) begin
			return '0;
		end
		return make_coef((2 * nn + 3) * (2 * nn - 1), 64'd1, 2 * nn - 1);
	endfunction

	localparam logic [63:0] COEF_C0 = make_coef(64'd2, 64'd1, 64'd2);
	localparam logic [63:0] COEF_C1 = make_coef(64'd6, 64'd1, 64'd2);

	// Clamp a wide signed sum into the 48-bit result range.
	function automatic logic signed [VW-1:0] sat_v(input logic signed [SUM_W-1:0] v);
		if (v[SUM_W-1:VW-1] == '0 || v[SUM_W-1:VW-1] == '1) begin
			return v[VW-1:0];
		end
		return v[SUM_W-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
	endfunction

endpackage

// File: src/lbe_if.sv
interface lbe_in_if import lbe_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic signed [XW-1:0] x_value;

	modport source(output valid, output x_value, input ready);
	modport sink(input valid, input x_value, output ready);
endinterface

interface lbe_out_if import lbe_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [DEG_W-1:0]     order;
	logic signed [VW-1:0] value;
	logic signed [VW-1:0] slope;
	logic                 last;

	modport source(output valid, output order, output value, output slope, output last,
		input ready);
	modport sink(input valid, input order, input value, input slope, input last,
		output ready);
endinterface

// File: src/legendre_basis_evaluator.sv
// Schedule: every product of an item runs in turn through the one shared 32x32 multiplier.
// Items: one at a time; the next item is taken after the last result of the previous one
// sits in the output register.
// Reset: arst_n is asynchronous and active low; the block comes up idle with degree 3.
module legendre_basis_evaluator import lbe_pkg::*; #(
	parameter int MAX_DEGREE = DEF_MAX_DEGREE,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	lbe_in_if.sink            sample,
	lbe_out_if.source         basis,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int ROM_N = MAX_DEGREE + 1;
	localparam int RIX_W = $clog2(ROM_N);

	// The constant 1.0 in the result format, used by the seed products.
	localparam logic signed [OPW-1:0] ONE = OPW'(1) << FRAC_BITS;

	localparam logic [APB_AW-3:0] REG_DEGREE = '0;
	localparam logic [2:0]        MC_LAST    = 3'd4;

	// The sequencer runs each product through load, four partial products, rounding,
	// clamping and a post step that folds the product into the recurrence.
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_LOAD  = 7'b0000010,
		S_MUL   = 7'b0000100,
		S_ROUND = 7'b0001000,
		S_DONE  = 7'b0010000,
		S_POST  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	// Products of one item, in the order they are issued. Seeds first, then five products
	// for every higher order: t = x*p_n, A*t, B*p_(n-1), C*p_n, D*d_(n-1).
	typedef enum logic [2:0] {
		OP_P0,
		OP_D1,
		OP_P1,
		OP_T,
		OP_AT,
		OP_BP,
		OP_CP,
		OP_DD
	} op_t;

	state_t state_q;
	op_t    op_q;

	logic [DEG_W-1:0] degree_q;
	logic [DEG_W-1:0] top_q;
	logic [DEG_W-1:0] ord_q;
	logic [2:0]       mc_q;

	// Recurrence state: x, the two newest values and slopes, a scratch product and the next value.
	logic signed [XW-1:0]     x_q;
	logic signed [VW-1:0]     pa_q;
	logic signed [VW-1:0]     pb_q;
	logic signed [VW-1:0]     da_q;
	logic signed [VW-1:0]     db_q;
	logic signed [VW-1:0]     pn_q;
	logic signed [MRES_W-1:0] hold_q;

	// Shared multiplier.
	logic [OPW-1:0]           a_mag_q;
	logic [OPW-1:0]           b_mag_q;
	logic                     neg_q;
	logic                     sh32_q;
	logic [OPW-1:0]           prod_q;
	logic [ACC_W-1:0]         acc_q;
	logic signed [MRES_W-1:0] mres_q;

	// Output register.
	logic                 out_valid_q;
	logic [DEG_W-1:0]     out_order_q;
	logic signed [VW-1:0] out_value_q;
	logic signed [VW-1:0] out_slope_q;
	logic                 out_last_q;

	// Coefficient tables, built at elaboration from the root and division functions.
	logic [63:0] rom_a [ROM_N];
	logic [63:0] rom_b [ROM_N];
	logic [63:0] rom_c [ROM_N];
	logic [63:0] rom_d [ROM_N];

	for (genvar g = 0; g < ROM_N; g++) begin : g_rom
		assign rom_a[g] = coef_a(g);
		assign rom_b[g] = coef_b(g);
		assign rom_c[g] = coef_c(g);
		assign rom_d[g] = coef_d(g);
	end

	logic [RIX_W-1:0] rix;
	assign rix = RIX_W'(ord_q);

	// ---------------------------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready is tied high.
	// ---------------------------------------------------------------------------------------
	logic reg_hit;
	assign reg_hit = (paddr[APB_AW-1:2] == REG_DEGREE);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? APB_DW'(degree_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			degree_q <= pwdata[DEG_W-1:0];
		end
	end

	// ---------------------------------------------------------------------------------------
	// Handshakes. An item is taken only when the sequencer is idle; results leave through a
	// one-deep output register so that the last result of an item can wait for the sink
	// while the next item is already being worked on.
	// ---------------------------------------------------------------------------------------
	logic take_in;
	logic emit_now;
	logic emit_last;

	assign sample.ready = (state_q == S_IDLE);
	assign take_in      = sample.valid && sample.ready;
	assign emit_now     = (state_q == S_EMIT) && (!out_valid_q || basis.ready);
	assign emit_last    = (ord_q == top_q);

	assign basis.valid = out_valid_q;
	assign basis.order = out_order_q;
	assign basis.value = out_value_q;
	assign basis.slope = out_slope_q;
	assign basis.last  = out_last_q;

	// Clamped abscissa and the effective top order for a new item.
	logic signed [XW-1:0] x_clamped;
	logic [DEG_W-1:0]     top_next;

	always_comb begin
		x_clamped = sample.x_value;
		if (sample.x_value > X_ONE) begin
			x_clamped = X_ONE;
		end else if (sample.x_value < X_NEG) begin
			x_clamped = X_NEG;
		end
		top_next = (int'(degree_q) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : degree_q;
	end

	// ---------------------------------------------------------------------------------------
	// Operand selection for the product named by op_q. Both operands go into the multiplier
	// as magnitudes; the sign of the product is kept aside and applied after rounding, which
	// gives rounding half away from zero.
	// ---------------------------------------------------------------------------------------
	logic signed [OPW-1:0] opa;
	logic signed [OPW-1:0] opb;
	logic                  op_sh32;

	always_comb begin
		opa     = '0;
		opb     = '0;
		op_sh32 = 1'b1;
		case (op_q)
			OP_P0: begin
				opa = signed'(COEF_C0);
				opb = ONE;
			end
			OP_D1: begin
				opa = signed'(COEF_C1);
				opb = ONE;
			end
			OP_P1: begin
				opa     = signed'(COEF_C1);
				opb     = OPW'(x_q);
				op_sh32 = 1'b0;
			end
			OP_T: begin
				opa     = OPW'(x_q);
				opb     = OPW'(pb_q);
				op_sh32 = 1'b0;
			end
			OP_AT: begin
				opa = signed'(rom_a[rix]);
				opb = OPW'(hold_q);
			end
			OP_BP: begin
				opa = signed'(rom_b[rix]);
				opb = OPW'(pa_q);
			end
			OP_CP: begin
				opa = signed'(rom_c[rix]);
				opb = OPW'(pb_q);
			end
			OP_DD: begin
				opa = signed'(rom_d[rix]);
				opb = OPW'(da_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// Partial products: mc_q bit 1 picks the half of a, bit 0 the half of b. Each product is
	// registered in prod_q and added into the accumulator in the following cycle.
	logic [HALF_W-1:0] a_half;
	logic [HALF_W-1:0] b_half;
	logic [1:0]        pp_idx;
	logic [ACC_W-1:0]  pp_addend;
	logic [ACC_W-1:0]  acc_base;

	assign a_half = mc_q[1] ? a_mag_q[OPW-1:HALF_W] : a_mag_q[HALF_W-1:0];
	assign b_half = mc_q[0] ? b_mag_q[OPW-1:HALF_W] : b_mag_q[HALF_W-1:0];
	assign pp_idx = 2'(mc_q - 3'd1);

	always_comb begin
		case (pp_idx)
			2'd0:    pp_addend = ACC_W'(prod_q);
			2'd3:    pp_addend = ACC_W'(prod_q) << (2 * HALF_W);
			default: pp_addend = ACC_W'(prod_q) << HALF_W;
		endcase
		acc_base = (mc_q == 3'd1) ? '0 : acc_q;
	end

	// Shift out the fraction, clamp the magnitude to 2^60, then apply the sign.
	logic [ACC_W-1:0] q_full;
	logic [MAG_W-1:0] q_mag;

	always_comb begin
		q_full = sh32_q ? (acc_q >> 32) : (acc_q >> 30);
		q_mag  = (q_full > MUL_LIM) ? MAG_W'(MUL_LIM) : q_full[MAG_W-1:0];
	end

	// Recurrence sums, saturated to the result range.
	logic signed [VW-1:0] mres_sat;
	logic signed [VW-1:0] p_sum;
	logic signed [VW-1:0] d_sum;

	assign mres_sat = sat_v(SUM_W'(mres_q));
	assign p_sum    = sat_v(SUM_W'(hold_q) - SUM_W'(mres_q));
	assign d_sum    = sat_v(SUM_W'(hold_q) + SUM_W'(mres_q));

	// ---------------------------------------------------------------------------------------
	// Sequencer.
	// ---------------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_P0;
			mc_q        <= '0;
			ord_q       <= '0;
			top_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (basis.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (take_in) begin
						top_q   <= top_next;
						ord_q   <= '0;
						op_q    <= OP_P0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					mc_q    <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					mc_q <= mc_q + 3'd1;
					if (mc_q == MC_LAST) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_POST;
				end
				S_POST: begin
					case (op_q)
						OP_P0: state_q <= S_EMIT;
						OP_D1: begin
							op_q    <= OP_P1;
							state_q <= S_LOAD;
						end
						OP_P1: begin
							ord_q   <= DEG_W'(1);
							state_q <= S_EMIT;
						end
						OP_T: begin
							op_q    <= OP_AT;
							state_q <= S_LOAD;
						end
						OP_AT: begin
							op_q    <= OP_BP;
							state_q <= S_LOAD;
						end
						OP_BP: begin
							op_q    <= OP_CP;
							state_q <= S_LOAD;
						end
						OP_CP: begin
							op_q    <= OP_DD;
							state_q <= S_LOAD;
						end
						OP_DD: begin
							ord_q   <= ord_q + DEG_W'(1);
							state_q <= S_EMIT;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_EMIT: begin
					if (emit_now) begin
						if (emit_last) begin
							state_q <= S_IDLE;
						end else begin
							// Order 1 is seeded; every later order starts with t = x*p_n.
							op_q    <= (ord_q == '0) ? OP_D1 : OP_T;
							state_q <= S_LOAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------------------------------
	// Datapath registers.
	// ---------------------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (take_in) begin
			x_q <= x_clamped;
		end

		if (state_q == S_LOAD) begin
			a_mag_q <= opa[OPW-1] ? unsigned'(-opa) : unsigned'(opa);
			b_mag_q <= opb[OPW-1] ? unsigned'(-opb) : unsigned'(opb);
			neg_q   <= opa[OPW-1] ^ opb[OPW-1];
			sh32_q  <= op_sh32;
		end

		if (state_q == S_MUL) begin
			prod_q <= OPW'(a_half) * OPW'(b_half);
			if (mc_q != '0) begin
				acc_q <= acc_base + pp_addend;
			end
		end

		if (state_q == S_ROUND) begin
			acc_q <= acc_q + (sh32_q ? (ACC_W'(1) << 31) : (ACC_W'(1) << 29));
		end

		if (state_q == S_DONE) begin
			mres_q <= neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
		end

		if (state_q == S_POST) begin
			case (op_q)
				OP_P0: begin
					pa_q <= mres_sat;
					pb_q <= mres_sat;
					da_q <= '0;
					db_q <= '0;
				end
				OP_D1: db_q <= mres_sat;
				OP_P1: pb_q <= mres_sat;
				OP_T:  hold_q <= mres_q;
				OP_AT: hold_q <= mres_q;
				OP_BP: pn_q <= p_sum;
				OP_CP: hold_q <= mres_q;
				OP_DD: begin
					pa_q <= pb_q;
					pb_q <= pn_q;
					da_q <= db_q;
					db_q <= d_sum;
				end
				default: hold_q <= hold_q;
			endcase
		end

		if (emit_now) begin
			out_order_q <= ord_q;
			out_value_q <= pb_q;
			out_slope_q <= db_q;
			out_last_q  <= emit_last;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------------------------------

	// A new item always starts from the order-zero seed.
	a_start_seed: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> (state_q == S_LOAD) && (op_q == OP_P0) && (ord_q == '0))
		else $error("item did not start from the order-zero seed");

	// Seed products are positive constants times 1.0, so they can never come out negative.
	a_seed_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POST) && (op_q == OP_P0 || op_q == OP_D1) |-> !mres_q[MRES_W-1])
		else $error("seed product came out negative");

	// Order zero leaves both value registers holding the same seed and the newest slope at zero.
	a_order0_state: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) && (ord_q == '0) |-> (pa_q == pb_q) && (db_q == '0))
		else $error("order-zero recurrence state is inconsistent");

endmodule

// File: tb/sv/tb_legendre_basis_evaluator.sv
module tb_legendre_basis_evaluator;
	import lbe_pkg::*;

	// Register map: degree is the only register, at byte address 0. Address 4 decodes to
	// a register that does not exist, so writes there must leave degree alone.
	localparam logic [APB_AW-1:0] DEGREE_ADDR = 3'd0;
	localparam logic [APB_AW-1:0] UNUSED_ADDR = 3'd4;

	localparam logic [DEG_W-1:0] DEGREE_AFTER_RESET = 5'd3;
	localparam longint           Q30_ONE            = 64'sd1073741824;
	localparam logic [127:0]     PRODUCT_CAP        = 128'd1 << 60;
	localparam longint           VALUE_MAX          = 64'sd140737488355327;
	localparam longint           VALUE_MIN          = -64'sd140737488355328;

	localparam int RANDOM_ITEMS  = 420;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 6000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 64;
	localparam int SHOWN_ERRORS  = 10;

	typedef struct packed {
		logic [DEG_W-1:0]     order;
		logic signed [VW-1:0] value;
		logic signed [VW-1:0] slope;
		logic                 last;
	} basis_t;

	// Keeps a mirror of the degree register and the queue of basis results still owed by
	// the block. Each accepted abscissa is expanded into its whole series right away.
	class legendre_scoreboard;
		logic [DEG_W-1:0] degree_mirror;
		basis_t           basis_due[$];
		int               errors;
		longint           rec_a[32], rec_b[32], rec_c[32], rec_d[32];
		longint           seed0, seed1;

		function new();
			degree_mirror = DEGREE_AFTER_RESET;
			errors        = 0;
			seed0         = coef_q32(2, 1, 2);
			seed1         = coef_q32(6, 1, 2);
			rec_a[0] = 0;
			rec_b[0] = 0;
			rec_c[0] = 0;
			rec_d[0] = 0;
			for (int n = 1; n < 32; n++) begin
				rec_a[n] = coef_q32((2 * n + 1) * (2 * n + 3), 1, n + 1);
				rec_b[n] = coef_q32((2 * n + 3) * (2 * n - 1), n, (2 * n - 1) * (n + 1));
				rec_c[n] = coef_q32((2 * n + 1) * (2 * n + 3), 1, 1);
				rec_d[n] = coef_q32((2 * n + 3) * (2 * n - 1), 1, 2 * n - 1);
			end
		endfunction

		// floor(sqrt(k * 2^80)), found one bit at a time from the top.
		function bit [127:0] scaled_root(bit [127:0] k);
			bit [127:0] target;
			bit [127:0] root;
			bit [127:0] trial;
			target = k << 80;
			root   = '0;
			for (int b = 50; b >= 0; b--) begin
				trial = root | (128'd1 << b);
				if (trial * trial <= target) begin
					root = trial;
				end
			end
			return root;
		endfunction

		// sqrt(k) * num / den as unsigned Q.32, rounded half up.
		function longint coef_q32(int k, int num, int den);
			bit [127:0] div;
			bit [127:0] quo;
			div = 128'(den) * 128'd256;
			quo = (scaled_root(128'(k)) * 128'(num) + (div >> 1)) / div;
			return longint'(quo[63:0]);
		endfunction

		// a*b/2^s, rounded half away from zero, magnitude capped at 2^60.
		function longint scaled_mul(longint a, longint b, int s);
			bit         neg;
			bit [127:0] ua;
			bit [127:0] ub;
			bit [127:0] q;
			neg = (a < 0) != (b < 0);
			ua  = (a < 0) ? 128'(-a) : 128'(a);
			ub  = (b < 0) ? 128'(-b) : 128'(b);
			q   = (ua * ub + (128'd1 << (s - 1))) >> s;
			if (q > PRODUCT_CAP) begin
				q = PRODUCT_CAP;
			end
			return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
		endfunction

		function longint clamp48(longint v);
			if (v > VALUE_MAX) begin
				return VALUE_MAX;
			end
			if (v < VALUE_MIN) begin
				return VALUE_MIN;
			end
			return v;
		endfunction

		function void owe(int n, longint v, longint d);
			basis_t r;
			r.order = DEG_W'(n);
			r.value = v[VW-1:0];
			r.slope = d[VW-1:0];
			r.last  = (n == int'(degree_mirror));
			basis_due.push_back(r);
		endfunction

		function void take_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
			if (addr == DEGREE_ADDR) begin
				degree_mirror = data[DEG_W-1:0];
			end
		endfunction

		function void complain(string what);
			errors++;
			if (errors <= SHOWN_ERRORS) begin
				$display("%s", what);
			end
		endfunction

		// Expands one abscissa into orders 0 .. degree. Orders 0 and 1 are seeded, the
		// rest follow the three-term value recurrence and the derivative recurrence.
		function void note_abscissa(logic signed [XW-1:0] x_raw);
			longint x, pa, pb, da, db, t, pn, dn;
			int     top;
			x = longint'(x_raw);
			if (x > Q30_ONE) begin
				x = Q30_ONE;
			end
			if (x < -Q30_ONE) begin
				x = -Q30_ONE;
			end
			top = int'(degree_mirror);
			pa  = clamp48(scaled_mul(seed0, Q30_ONE, 32));
			da  = 0;
			owe(0, pa, da);
			pb = pa;
			db = da;
			if (top >= 1) begin
				pb = clamp48(scaled_mul(seed1, x, 30));
				db = clamp48(scaled_mul(seed1, Q30_ONE, 32));
				owe(1, pb, db);
			end
			for (int n = 1; n < top; n++) begin
				t  = scaled_mul(x, pb, 30);
				pn = clamp48(scaled_mul(rec_a[n], t, 32) - scaled_mul(rec_b[n], pa, 32));
				dn = clamp48(scaled_mul(rec_c[n], pb, 32) + scaled_mul(rec_d[n], da, 32));
				pa = pb;
				pb = pn;
				da = db;
				db = dn;
				owe(n + 1, pb, db);
			end
		endfunction

		function void check_basis(basis_t got);
			basis_t want;
			if (basis_due.size() == 0) begin
				complain($sformatf("unexpected result: order %0d value %0d slope %0d last %0b",
					got.order, got.value, got.slope, got.last));
				return;
			end
			want = basis_due.pop_front();
			if (got.order !== want.order || got.value !== want.value ||
					got.slope !== want.slope || got.last !== want.last) begin
				complain($sformatf("mismatch order %0d/%0d last %0b/%0b (got/exp)",
					got.order, want.order, got.last, want.last));
				if (errors <= SHOWN_ERRORS) begin
					$display("  value got %0d exp %0d, slope got %0d exp %0d",
						got.value, want.value, got.slope, want.slope);
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	lbe_in_if  sample_if();
	lbe_out_if basis_if();

	legendre_basis_evaluator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_if.sink),
		.basis  (basis_if.source),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	legendre_scoreboard sb = new();

	// Random gaps on both channels are switched off for a few phases so that the block
	// also sees back-to-back traffic. A hold request makes the result side stop taking
	// items for a long stretch while the sender keeps offering.
	bit gaps_on      = 1'b1;
	bit hold_request = 1'b0;
	int idle_cycles  = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Result side: ready changes at the falling edge only.
	initial begin
		int hold_left;
		hold_left      = 0;
		basis_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (!arst_n) begin
				basis_if.ready = 1'b0;
			end else if (hold_left > 0) begin
				basis_if.ready = 1'b0;
				hold_left--;
			end else if (!gaps_on) begin
				basis_if.ready = 1'b1;
			end else begin
				basis_if.ready = ($urandom_range(99) >= 15);
			end
		end
	end

	// Every accepted result is checked at the rising edge, and the watchdog counts the
	// cycles in which neither channel moved an item.
	always @(posedge clk) begin
		basis_t got;
		if (arst_n && basis_if.valid && basis_if.ready) begin
			got.order = basis_if.order;
			got.value = basis_if.value;
			got.slope = basis_if.slope;
			got.last  = basis_if.last;
			sb.check_basis(got);
		end
		if ((basis_if.valid && basis_if.ready) || (sample_if.valid && sample_if.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
			$display("** legendre_basis_evaluator: FAILED **");
			$finish;
		end
	end

	// Offers one abscissa, possibly after a few idle cycles, and returns at the falling
	// edge after it was taken. Valid stays high if the next call brings no gap.
	task automatic offer_abscissa(input logic signed [XW-1:0] x);
		while (gaps_on && $urandom_range(99) < 15) begin
			sample_if.valid   = 1'b0;
			sample_if.x_value = $urandom();
			@(negedge clk);
		end
		sample_if.valid   = 1'b1;
		sample_if.x_value = x;
		do @(posedge clk); while (!sample_if.ready);
		sb.note_abscissa(x);
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = addr;
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.take_write(addr, data);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic check_degree_readback();
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = DEGREE_ADDR;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DW'(sb.degree_mirror)) begin
			sb.complain($sformatf("degree read back %0h, expected %0h", prdata,
				sb.degree_mirror));
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	// Junk in the upper bits of the write data must be dropped by the register.
	task automatic set_degree(input int unsigned deg);
		logic [APB_DW-1:0] word;
		word             = $urandom();
		word[DEG_W-1:0]  = deg[DEG_W-1:0];
		reg_write(DEGREE_ADDR, word);
	endtask

	// The block is idle once its last result has been taken; give it a few cycles more
	// before the register is touched.
	task automatic wait_drained();
		sample_if.valid = 1'b0;
		while (sb.basis_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly in-range abscissas, with the endpoints, zero and raw 32-bit words mixed in.
	// The raw words fall outside [-1,1] about half the time and exercise the clamp.
	function automatic logic signed [XW-1:0] pick_abscissa();
		int unsigned kind;
		longint      offset;
		kind = $urandom_range(19);
		case (kind)
			0: return X_ONE;
			1: return X_NEG;
			2: return '0;
			3, 4, 5: return $urandom();
			default: begin
				offset = longint'($urandom_range(32'h8000_0000, 0));
				return XW'(offset - Q30_ONE);
			end
		endcase
	endfunction

	initial begin
		logic signed [XW-1:0] directed_x[$];
		int                   sent;
		int                   phase;
		int unsigned          deg;
		int unsigned          count;
		int unsigned          pick;

		arst_n            = 1'b0;
		sample_if.valid   = 1'b0;
		sample_if.x_value = '0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset degree: both endpoints, zero, the most extreme words
		// that need clamping, values one step beyond the endpoints, the smallest nonzero
		// magnitudes of both signs, and plus and minus one half and one third.
		directed_x = {X_ONE, X_NEG, 32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh4000_0001, 32'shBFFF_FFFF, 32'sd1, -32'sd1, 32'sh2000_0000,
			32'shE000_0000, 32'sh1555_5555, 32'shEAAA_AAAB};
		check_degree_readback();
		foreach (directed_x[i]) begin
			offer_abscissa(directed_x[i]);
		end

		// Degree zero yields a single result with last set.
		wait_drained();
		reg_write(DEGREE_ADDR, 32'hFFFF_FFE0);
		check_degree_readback();
		offer_abscissa(X_ONE);
		offer_abscissa(X_NEG);

		// A write to an address with no register behind it must not change the degree.
		wait_drained();
		reg_write(UNUSED_ADDR, 32'hFFFF_FFFF);
		check_degree_readback();
		offer_abscissa(32'sh1234_5678);

		// Highest degree at the endpoints, where the slopes grow largest, and just inside the top one.
		wait_drained();
		set_degree(31);
		check_degree_readback();
		offer_abscissa(X_ONE);
		offer_abscissa(X_NEG);
		offer_abscissa(32'sh3FFF_FFFF);

		// Random phases. Most use small degrees so that the run stays short; a few go to
		// the top degree or somewhere in between.
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_drained();
			gaps_on = !(phase >= 6 && phase <= 8);
			pick    = $urandom_range(9);
			if (pick < 6) begin
				deg   = $urandom_range(6, 1);
				count = $urandom_range(40, 15);
			end else if (pick == 6) begin
				deg   = 0;
				count = $urandom_range(30, 10);
			end else if (pick == 7) begin
				deg   = 31;
				count = $urandom_range(4, 2);
			end else begin
				deg   = $urandom_range(31, 7);
				count = $urandom_range(6, 2);
			end
			if (phase == 4) begin
				deg   = 5;
				count = 20;
			end
			if ($urandom_range(3) == 0) begin
				reg_write(UNUSED_ADDR, $urandom());
			end
			set_degree(deg);
			if ($urandom_range(3) == 0) begin
				check_degree_readback();
			end
			for (int i = 0; i < int'(count) && sent < RANDOM_ITEMS; i++) begin
				if (phase == 4 && i == 1) begin
					hold_request = 1'b1;
				end
				offer_abscissa(pick_abscissa());
				sent++;
			end
			sample_if.valid = 1'b0;
			phase++;
		end

		while (sb.basis_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.basis_due.size() != 0) begin
			sb.complain($sformatf("%0d results never arrived", sb.basis_due.size()));
		end
		if (sb.errors == 0) begin
			$display("** legendre_basis_evaluator: PASSED **");
		end else begin
			$display("** legendre_basis_evaluator: FAILED **");
		end
		$finish;
	end

endmodule

// File: files.f
src/lbe_pkg.sv
src/lbe_if.sv
src/legendre_basis_evaluator.sv
tb/sv/tb_legendre_basis_evaluator.sv
